[hdl/assert_macros.svh]
// Assertion macros used by the RTL file of the hostname extractor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that a property holds at every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// Checks that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

[hdl/tlssni_pkg.sv]
// Constants and types of the TLS SNI hostname extractor.
`timescale 1ns / 1ps
`default_nettype none
package tlssni_pkg;

  // Width of the sampled packet length.
  localparam int unsigned LENGTH_BITS = 16;
  // Width of byte positions within a packet.
  localparam int unsigned POS_W = 18;

  typedef logic [LENGTH_BITS-1:0] len_t;
  typedef logic [POS_W-1:0]       pos_t;
  typedef logic [POS_W:0]         wpos_t;

  localparam logic [7:0]  TLS_HANDSHAKE   = 8'h16;
  localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
  localparam logic [7:0]  SNI_HOST_NAME   = 8'h00;
  localparam logic [15:0] VERSION_MIN     = 16'h0300;
  localparam logic [15:0] VERSION_MAX     = 16'h0304;
  localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;

  localparam int unsigned MIN_PKT_LEN  = 9;
  localparam int unsigned RANDOM_LEN   = 32;
  localparam int unsigned REC_HDR_LEN  = 5;
  localparam int unsigned EXT_HDR_LEN  = 4;
  localparam int unsigned SNI_MIN_LIST = 3;
  localparam int unsigned SNI_MIN_EXT  = 5;
  // Session id length byte: record header, handshake header, version, random.
  localparam int unsigned SID_POS = REC_HDR_LEN + 4 + 2 + RANDOM_LEN;

  // Result queue.
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_AW    = $clog2(RES_DEPTH);

  // Output kinds.
  localparam logic KIND_NAME    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] name_byte;
    logic       name_last;
    logic       found;
  } result_t;

endpackage
`default_nettype wire

[hdl/tls_sni_hostname_extractor.sv]
// Top level of the TLS ClientHello SNI hostname extractor.
//
// Packet payload bytes enter on the s_axis channel, one byte per beat.
// tuser marks the first byte of a packet, which restarts parsing and carries
// the packet length in tdata; tlast marks the final byte of the packet.
// Results leave on the m_axis channel: tuser is 0 for a hostname byte, with
// tlast on its final byte, and 1 for the verdict given on the last packet
// byte, with the found bit in tdata.
// Each accepted byte is parsed in the cycle it is accepted; its results go
// into the result queue feeding m_axis, at a sustained rate of one input
// beat per cycle while the receiver keeps up. The parse state and a
// four-entry result queue set that figure: a byte can push up to two
// results, so s_axis_tready_o is high while at least two queue entries are
// free. When the receiver stalls, the input stalls once over two results wait.
// Reset empties the queue and leaves the parser waiting for a first byte;
// bytes before any first byte are ignored, but a last byte there still
// yields a not-found verdict.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tls_sni_hostname_extractor (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // tdata: data_byte [7:0], packet_length [23:8]
  input  wire logic [23:0] s_axis_tdata_i,
  // tuser: first_flag [0]
  input  wire logic        s_axis_tuser_i,
  input  wire logic        s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // tdata: name_byte [7:0], found [8], zero [15:9]
  output logic [15:0]      m_axis_tdata_o,
  // tuser: out_kind [0]
  output logic             m_axis_tuser_o,
  output logic             m_axis_tlast_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DONE, ST_HDR, ST_SID, ST_CS, ST_CM,
    ST_EXTLEN, ST_EXTHDR, ST_SNI, ST_NAME
  } stage_e;

  stage_e                  stage_q, stage_d;
  tlssni_pkg::pos_t        pos_q, pos_d;
  tlssni_pkg::pos_t        nfp_q, nfp_d;
  tlssni_pkg::len_t        held_q, held_d;
  logic [7:0]              acc_q, acc_d;
  tlssni_pkg::pos_t        ext_end_q, ext_end_d;
  logic [15:0]             ext_len_q, ext_len_d;
  logic [15:0]             ext_type_q, ext_type_d;
  logic [15:0]             names_q, names_d;
  logic                    found_q, found_d;

  tlssni_pkg::result_t     res_q [tlssni_pkg::RES_DEPTH];
  logic [tlssni_pkg::RES_AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [tlssni_pkg::RES_AW:0]   cnt_q, cnt_d;

  logic                    s_fire, m_fire;
  logic [7:0]              in_byte;
  tlssni_pkg::len_t        in_len;
  logic                    in_first, in_last;

  // Parser state after a first byte is taken into account.
  stage_e                  cur_stage;
  tlssni_pkg::pos_t        cur_pos, cur_nfp, cur_ext_end;
  tlssni_pkg::len_t        cur_held;
  logic [7:0]              cur_acc;
  logic [15:0]             cur_ext_len, cur_ext_type, cur_names;
  logic                    cur_found;

  tlssni_pkg::pos_t        idx;
  logic [15:0]             word;
  logic                    eligible;
  logic                    name_push, name_last;
  logic [15:0]             names_dec;
  tlssni_pkg::wpos_t       body, sum;
  tlssni_pkg::result_t     ent0, ent1, head;
  logic [1:0]              push_n;

  // Decides between the next extension header and the end of parsing.
  function automatic stage_e ext_next(tlssni_pkg::pos_t nfp, tlssni_pkg::pos_t ext_end);
    tlssni_pkg::wpos_t hdr_end;
    hdr_end = tlssni_pkg::wpos_t'(nfp) + tlssni_pkg::wpos_t'(tlssni_pkg::EXT_HDR_LEN);
    if (hdr_end > tlssni_pkg::wpos_t'(ext_end)) begin
      return ST_DONE;
    end
    return ST_EXTHDR;
  endfunction

  assign in_byte  = s_axis_tdata_i[7:0];
  assign in_len   = tlssni_pkg::len_t'(s_axis_tdata_i[23:8]);
  assign in_first = s_axis_tuser_i;
  assign in_last  = s_axis_tlast_i;

  assign s_axis_tready_o = (cnt_q <= (tlssni_pkg::RES_AW+1)'(tlssni_pkg::RES_DEPTH - 2));
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_fire          = m_axis_tvalid_o && m_axis_tready_i;

  assign head           = res_q[rd_ptr_q];
  assign m_axis_tdata_o = {7'b0, head.found, head.name_byte};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.name_last;

  always_comb begin
    if (in_first) begin
      cur_held     = in_len;
      cur_stage    = (in_len < tlssni_pkg::len_t'(tlssni_pkg::MIN_PKT_LEN)) ? ST_DONE : ST_HDR;
      cur_pos      = '0;
      cur_nfp      = '0;
      cur_acc      = '0;
      cur_ext_end  = '0;
      cur_ext_len  = '0;
      cur_ext_type = '0;
      cur_names    = '0;
      cur_found    = 1'b0;
    end else begin
      cur_held     = held_q;
      cur_stage    = stage_q;
      cur_pos      = pos_q;
      cur_nfp      = nfp_q;
      cur_acc      = acc_q;
      cur_ext_end  = ext_end_q;
      cur_ext_len  = ext_len_q;
      cur_ext_type = ext_type_q;
      cur_names    = names_q;
      cur_found    = found_q;
    end
  end

  always_comb begin
    idx       = cur_pos - cur_nfp;
    word      = {cur_acc, in_byte};
    names_dec = cur_names - 16'd1;
    eligible  = (cur_stage != ST_IDLE) && (cur_stage != ST_DONE) &&
                (cur_pos < tlssni_pkg::pos_t'(cur_held)) && (cur_pos >= cur_nfp);
    body      = tlssni_pkg::wpos_t'(cur_nfp) + tlssni_pkg::wpos_t'(tlssni_pkg::EXT_HDR_LEN);
    sum       = '0;
    name_push = 1'b0;
    name_last = 1'b0;

    stage_d    = cur_stage;
    nfp_d      = cur_nfp;
    held_d     = cur_held;
    acc_d      = cur_acc;
    ext_end_d  = cur_ext_end;
    ext_len_d  = cur_ext_len;
    ext_type_d = cur_ext_type;
    names_d    = cur_names;
    found_d    = cur_found;

    if (eligible) begin
      case (cur_stage)
        ST_HDR: begin
          if (idx == tlssni_pkg::pos_t'(0)) begin
            if (in_byte != tlssni_pkg::TLS_HANDSHAKE) stage_d = ST_DONE;
          end else if (idx == tlssni_pkg::pos_t'(1) || idx == tlssni_pkg::pos_t'(3)) begin
            acc_d = in_byte;
          end else if (idx == tlssni_pkg::pos_t'(2)) begin
            if (word < tlssni_pkg::VERSION_MIN || word > tlssni_pkg::VERSION_MAX) begin
              stage_d = ST_DONE;
            end
          end else if (idx == tlssni_pkg::pos_t'(4)) begin
            // Record length must fit behind the record header.
            if (tlssni_pkg::wpos_t'(word) > tlssni_pkg::wpos_t'(cur_held) -
                tlssni_pkg::wpos_t'(tlssni_pkg::REC_HDR_LEN)) begin
              stage_d = ST_DONE;
            end
          end else if (idx == tlssni_pkg::pos_t'(5)) begin
            if (in_byte != tlssni_pkg::HS_CLIENT_HELLO) begin
              stage_d = ST_DONE;
            end else begin
              nfp_d   = tlssni_pkg::pos_t'(tlssni_pkg::SID_POS);
              stage_d = ST_SID;
            end
          end
        end
        ST_SID: begin
          nfp_d   = cur_pos + tlssni_pkg::pos_t'(1) + tlssni_pkg::pos_t'(in_byte);
          stage_d = ST_CS;
        end
        ST_CS: begin
          if (idx == tlssni_pkg::pos_t'(0)) begin
            acc_d = in_byte;
          end else begin
            nfp_d   = cur_nfp + tlssni_pkg::pos_t'(2) + tlssni_pkg::pos_t'(word);
            stage_d = ST_CM;
          end
        end
        ST_CM: begin
          nfp_d   = cur_pos + tlssni_pkg::pos_t'(1) + tlssni_pkg::pos_t'(in_byte);
          stage_d = ST_EXTLEN;
        end
        ST_EXTLEN: begin
          if (idx == tlssni_pkg::pos_t'(0)) begin
            acc_d = in_byte;
          end else begin
            nfp_d = cur_nfp + tlssni_pkg::pos_t'(2);
            sum   = tlssni_pkg::wpos_t'(nfp_d) + tlssni_pkg::wpos_t'(word);
            // The extension block may not run past the packet.
            if (sum > tlssni_pkg::wpos_t'(cur_held)) begin
              ext_end_d = tlssni_pkg::pos_t'(cur_held);
            end else begin
              ext_end_d = tlssni_pkg::pos_t'(sum);
            end
            stage_d = ext_next(nfp_d, ext_end_d);
          end
        end
        ST_EXTHDR: begin
          if (idx == tlssni_pkg::pos_t'(0) || idx == tlssni_pkg::pos_t'(2)) begin
            acc_d = in_byte;
          end else if (idx == tlssni_pkg::pos_t'(1)) begin
            ext_type_d = word;
          end else if (idx == tlssni_pkg::pos_t'(3)) begin
            ext_len_d = word;
            sum       = body + tlssni_pkg::wpos_t'(word);
            if (sum > tlssni_pkg::wpos_t'(cur_ext_end)) begin
              stage_d = ST_DONE;
            end else if (cur_ext_type == tlssni_pkg::EXT_SERVER_NAME) begin
              if (word < 16'(tlssni_pkg::SNI_MIN_EXT)) begin
                stage_d = ST_DONE;
              end else begin
                nfp_d   = tlssni_pkg::pos_t'(body);
                stage_d = ST_SNI;
              end
            end else begin
              nfp_d   = tlssni_pkg::pos_t'(sum);
              stage_d = ext_next(nfp_d, cur_ext_end);
            end
          end
        end
        ST_SNI: begin
          if (idx == tlssni_pkg::pos_t'(0) || idx == tlssni_pkg::pos_t'(3)) begin
            acc_d = in_byte;
          end else if (idx == tlssni_pkg::pos_t'(1)) begin
            if (word < 16'(tlssni_pkg::SNI_MIN_LIST)) stage_d = ST_DONE;
          end else if (idx == tlssni_pkg::pos_t'(2)) begin
            if (in_byte != tlssni_pkg::SNI_HOST_NAME) stage_d = ST_DONE;
          end else if (idx == tlssni_pkg::pos_t'(4)) begin
            if (word > cur_ext_len - 16'(tlssni_pkg::SNI_MIN_EXT)) begin
              stage_d = ST_DONE;
            end else if (word == 16'd0) begin
              // An empty name still counts as found.
              found_d = 1'b1;
              stage_d = ST_DONE;
            end else begin
              names_d = word;
              stage_d = ST_NAME;
            end
          end
        end
        ST_NAME: begin
          names_d   = names_dec;
          name_push = 1'b1;
          name_last = (names_dec == 16'd0);
          if (names_dec == 16'd0) begin
            found_d = 1'b1;
            stage_d = ST_DONE;
          end
        end
        default: begin
        end
      endcase
    end

    if (cur_stage != ST_IDLE) begin
      pos_d = (&cur_pos) ? cur_pos : cur_pos + tlssni_pkg::pos_t'(1);
    end else begin
      pos_d = cur_pos;
    end

    ent0.kind      = tlssni_pkg::KIND_NAME;
    ent0.name_byte = in_byte;
    ent0.name_last = name_last;
    ent0.found     = 1'b0;
    ent1.kind      = tlssni_pkg::KIND_VERDICT;
    ent1.name_byte = 8'd0;
    ent1.name_last = 1'b0;
    ent1.found     = found_d;
    if (!name_push) ent0 = ent1;
    push_n = s_fire ? ({1'b0, name_push} + {1'b0, in_last}) : 2'd0;

    // The verdict closes the packet and returns the parser to idle.
    if (in_last) begin
      stage_d    = ST_IDLE;
      pos_d      = '0;
      nfp_d      = '0;
      held_d     = '0;
      acc_d      = '0;
      ext_end_d  = '0;
      ext_len_d  = '0;
      ext_type_d = '0;
      names_d    = '0;
      found_d    = 1'b0;
    end

    wr_ptr_d = wr_ptr_q + tlssni_pkg::RES_AW'(push_n);
    rd_ptr_d = rd_ptr_q + tlssni_pkg::RES_AW'(m_fire);
    cnt_d    = cnt_q + (tlssni_pkg::RES_AW+1)'(push_n) - (tlssni_pkg::RES_AW+1)'(m_fire);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q    <= ST_IDLE;
      pos_q      <= '0;
      nfp_q      <= '0;
      held_q     <= '0;
      acc_q      <= '0;
      ext_end_q  <= '0;
      ext_len_q  <= '0;
      ext_type_q <= '0;
      names_q    <= '0;
      found_q    <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
    end else begin
      if (s_fire) begin
        stage_q    <= stage_d;
        pos_q      <= pos_d;
        nfp_q      <= nfp_d;
        held_q     <= held_d;
        acc_q      <= acc_d;
        ext_end_q  <= ext_end_d;
        ext_len_q  <= ext_len_d;
        ext_type_q <= ext_type_d;
        names_q    <= names_d;
        found_q    <= found_d;
      end
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Result queue storage; a beat that pushes two results fills two entries.
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) res_q[wr_ptr_q] <= ent0;
    if (push_n == 2'd2) res_q[wr_ptr_q + tlssni_pkg::RES_AW'(1)] <= ent1;
  end

  `ASSERT_NEVER(a_queue_overflow, clk_i, rst_ni,
    cnt_q > (tlssni_pkg::RES_AW+1)'(tlssni_pkg::RES_DEPTH))
  `ASSERT_AT(a_last_name_sets_found, clk_i, rst_ni,
    (s_fire && name_push && name_last && !in_last) |=> found_q)
  `ASSERT_AT(a_verdict_goes_idle, clk_i, rst_ni,
    (s_fire && in_last) |=> (stage_q == ST_IDLE && found_q == 1'b0))
  `ASSERT_AT(a_push_wakes_output, clk_i, rst_ni,
    (push_n != 2'd0) |=> m_axis_tvalid_o)

endmodule
`default_nettype wire

[dv/tls_sni_hostname_checker.sv]
// Checker that predicts and compares the result beats of the SNI hostname extractor.
`timescale 1ns / 1ps
module tls_sni_hostname_checker
  import tlssni_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  // tdata: data_byte [7:0], packet_length [23:8]
  input  logic [23:0] s_tdata_i,
  // tuser: first_flag [0]
  input  logic        s_tuser_i,
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  // tdata: name_byte [7:0], found [8], zero [15:9]
  input  logic [15:0] m_tdata_i,
  // tuser: out_kind [0]
  input  logic        m_tuser_i,
  input  logic        m_tlast_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned name_beats_o,
  output int unsigned verdicts_o,
  output int unsigned found_o
);

  typedef enum logic [4:0] {
    PS_IDLE, PS_DONE, PS_HDR, PS_SID, PS_CS, PS_CM, PS_EXTLEN, PS_EXTHDR, PS_SNI, PS_NAME
  } parse_stage_e;

  localparam pos_t POS_SAT = '1;

  parse_stage_e stage;
  pos_t         byte_pos;
  pos_t         next_pos;
  pos_t         ext_end;
  len_t         pkt_len;
  logic [15:0]  field_acc;
  len_t         ext_len;
  len_t         ext_type;
  len_t         name_left;
  logic         found_seen;

  result_t      expected_results[$];
  result_t      want;
  result_t      got;

  task automatic clear_packet_state();
    stage      = PS_IDLE;
    byte_pos   = '0;
    next_pos   = '0;
    pkt_len    = '0;
    field_acc  = '0;
    ext_end    = '0;
    ext_len    = '0;
    ext_type   = '0;
    name_left  = '0;
    found_seen = 1'b0;
  endtask

  task automatic pick_next_extension();
    if (32'(next_pos) + EXT_HDR_LEN > 32'(ext_end)) begin
      stage = PS_DONE;
    end else begin
      stage = PS_EXTHDR;
    end
  endtask

  // Parses one byte that lies inside the packet at or after the next field.
  task automatic parse_one(input pos_t p, input logic [7:0] b);
    int unsigned idx;
    int unsigned v;
    int unsigned body;
    int unsigned sum;
    idx = 32'(p) - 32'(next_pos);
    v   = (32'(field_acc) << 8) | 32'(b);
    case (stage)
      PS_HDR: begin
        if (idx == 0) begin
          if (b != TLS_HANDSHAKE) stage = PS_DONE;
        end else if (idx == 1 || idx == 3) begin
          field_acc = 16'(b);
        end else if (idx == 2) begin
          if (v < VERSION_MIN || v > VERSION_MAX) stage = PS_DONE;
        end else if (idx == 4) begin
          if (v > 32'(pkt_len) - REC_HDR_LEN) stage = PS_DONE;
        end else if (idx == 5) begin
          if (b != HS_CLIENT_HELLO) begin
            stage = PS_DONE;
          end else begin
            next_pos = pos_t'(SID_POS);
            stage    = PS_SID;
          end
        end
      end
      PS_SID: begin
        next_pos = pos_t'(32'(p) + 1 + 32'(b));
        stage    = PS_CS;
      end
      PS_CS: begin
        if (idx == 0) begin
          field_acc = 16'(b);
        end else begin
          next_pos = pos_t'(32'(next_pos) + 2 + v);
          stage    = PS_CM;
        end
      end
      PS_CM: begin
        next_pos = pos_t'(32'(p) + 1 + 32'(b));
        stage    = PS_EXTLEN;
      end
      PS_EXTLEN: begin
        if (idx == 0) begin
          field_acc = 16'(b);
        end else begin
          next_pos = pos_t'(32'(next_pos) + 2);
          sum      = 32'(next_pos) + v;
          // The extension list never reaches past the packet.
          if (sum > 32'(pkt_len)) sum = 32'(pkt_len);
          ext_end = pos_t'(sum);
          pick_next_extension();
        end
      end
      PS_EXTHDR: begin
        if (idx == 0 || idx == 2) begin
          field_acc = 16'(b);
        end else if (idx == 1) begin
          ext_type = len_t'(v);
        end else if (idx == 3) begin
          body    = 32'(next_pos) + EXT_HDR_LEN;
          ext_len = len_t'(v);
          if (body + 32'(ext_len) > 32'(ext_end)) begin
            stage = PS_DONE;
          end else if (ext_type == EXT_SERVER_NAME) begin
            if (32'(ext_len) < SNI_MIN_EXT) begin
              stage = PS_DONE;
            end else begin
              next_pos = pos_t'(body);
              stage    = PS_SNI;
            end
          end else begin
            next_pos = pos_t'(body + 32'(ext_len));
            pick_next_extension();
          end
        end
      end
      PS_SNI: begin
        if (idx == 0 || idx == 3) begin
          field_acc = 16'(b);
        end else if (idx == 1) begin
          if (v < SNI_MIN_LIST) stage = PS_DONE;
        end else if (idx == 2) begin
          if (b != SNI_HOST_NAME) stage = PS_DONE;
        end else if (idx == 4) begin
          if (v > 32'(ext_len) - SNI_MIN_EXT) begin
            stage = PS_DONE;
          end else if (v == 0) begin
            // An empty name still counts as found.
            found_seen = 1'b1;
            stage      = PS_DONE;
          end else begin
            name_left = len_t'(v);
            stage     = PS_NAME;
          end
        end
      end
      PS_NAME: begin
        name_left = name_left - 1'b1;
        expected_results.push_back('{kind: KIND_NAME, name_byte: b,
                                     name_last: (name_left == '0), found: 1'b0});
        if (name_left == '0) begin
          found_seen = 1'b1;
          stage      = PS_DONE;
        end
      end
      default: ;
    endcase
  endtask

  task automatic predict_beat(input logic [7:0] b, input logic first, input logic last,
                              input len_t plen);
    pos_t p;
    if (first) begin
      clear_packet_state();
      pkt_len = plen;
      stage   = (32'(pkt_len) < MIN_PKT_LEN) ? PS_DONE : PS_HDR;
    end
    if (stage != PS_IDLE) begin
      p = byte_pos;
      if (p < pkt_len && p >= next_pos && stage != PS_DONE) parse_one(p, b);
      byte_pos = (p < POS_SAT) ? p + 1'b1 : POS_SAT;
    end
    if (last) begin
      expected_results.push_back('{kind: KIND_VERDICT, name_byte: 8'h00, name_last: 1'b0,
                                   found: found_seen});
      clear_packet_state();
    end
  endtask

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_results.delete();
      clear_packet_state();
      mismatches_o = 0;
      pending_o    = 0;
      name_beats_o = 0;
      verdicts_o   = 0;
      found_o      = 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        predict_beat(s_tdata_i[7:0], s_tuser_i, s_tlast_i, s_tdata_i[23:8]);
      end
      if (m_tvalid_i && m_tready_i) begin
        got = '{kind: m_tuser_i, name_byte: m_tdata_i[7:0], name_last: m_tlast_i,
                found: m_tdata_i[8]};
        if (got.kind == KIND_VERDICT) begin
          verdicts_o++;
          if (got.found) found_o++;
        end else begin
          name_beats_o++;
        end
        if (expected_results.size() == 0) begin
          $error("unexpected result beat: kind %0d byte 0x%0h last %0d found %0d",
                 got.kind, got.name_byte, got.name_last, got.found);
          mismatches_o++;
        end else begin
          want = expected_results.pop_front();
          check_field("out_kind", want.kind, got.kind);
          check_field("name_byte", want.name_byte, got.name_byte);
          check_field("name_last", want.name_last, got.name_last);
          check_field("found", want.found, got.found);
          check_field("tdata padding", 0, m_tdata_i[15:9]);
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

[dv/tls_sni_hostname_extractor_test.sv]
// Testbench top that drives ClientHello packets into the SNI hostname extractor.
`timescale 1ns / 1ps
module tls_sni_hostname_extractor_test;
  import tlssni_pkg::*;

  typedef enum int unsigned {
    PK_GOOD, PK_EMPTY_NAME, PK_NO_SNI, PK_CORRUPT, PK_BAD_SNI,
    PK_TRUNCATED, PK_UNFINISHED, PK_SHORT, PK_OVERRUN, PK_LONG_LEN
  } pkt_kind_e;

  localparam int unsigned KIND_COUNT    = 10;
  localparam int unsigned BEATS_PER_RUN = 550;
  // Smallest accepted header: record length equal to packet length minus five.
  localparam logic [71:0] MIN_HELLO = 72'h16_03_04_00_04_01_00_00_00;

  logic        clk_i;
  logic        rst_n           = 1'b0;
  logic        s_axis_tvalid   = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata    = '0;
  logic        s_axis_tuser    = 1'b0;
  logic        s_axis_tlast    = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready   = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  int unsigned send_idle_pct   = 23;
  int unsigned recv_idle_pct   = 81;
  int unsigned packet_beats    = 0;
  int unsigned packets_sent    = 0;

  int unsigned mismatches;
  int unsigned pending_results;
  int unsigned name_beats;
  int unsigned verdicts;
  int unsigned found_verdicts;

  tls_sni_hostname_extractor u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  tls_sni_hostname_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .s_tlast_i    (s_axis_tlast),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .m_tlast_i    (m_axis_tlast),
    .mismatches_o (mismatches),
    .pending_o    (pending_results),
    .name_beats_o (name_beats),
    .verdicts_o   (verdicts),
    .found_o      (found_verdicts)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin
    #5_000_000;
    $display("** tls_sni_hostname_extractor: FAILED **");
    $finish;
  end

  // Offers one beat after a random number of idle cycles and returns at the
  // falling edge after it was accepted.
  task automatic send_beat(input logic [7:0] b, input logic first, input logic last,
                           input len_t plen);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 24'($urandom);
      s_axis_tuser  <= 1'($urandom);
      s_axis_tlast  <= 1'($urandom);
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {plen, b};
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending_results != 0) @(negedge clk_i);
  endtask

  function automatic pkt_kind_e choose_kind(input int unsigned serial);
    int unsigned roll;
    // The first packets walk through every kind once.
    if (serial < KIND_COUNT) return pkt_kind_e'(serial);
    roll = $urandom_range(0, 99);
    if (roll < 35) return PK_GOOD;
    if (roll < 40) return PK_EMPTY_NAME;
    if (roll < 48) return PK_NO_SNI;
    if (roll < 63) return PK_CORRUPT;
    if (roll < 73) return PK_BAD_SNI;
    if (roll < 81) return PK_TRUNCATED;
    if (roll < 86) return PK_UNFINISHED;
    if (roll < 91) return PK_SHORT;
    if (roll < 96) return PK_OVERRUN;
    return PK_LONG_LEN;
  endfunction

  // Builds a ClientHello with random content, breaks it as the kind asks,
  // and sends it.
  task automatic run_packet(input pkt_kind_e kind);
    logic [7:0]  pkt[$];
    int unsigned spots[$];
    int unsigned sni_spots[$];
    int unsigned ext_len_at;
    int unsigned ext_start;
    int unsigned n_before;
    int unsigned n_slots;
    int unsigned name_len;
    int unsigned sid_len;
    int unsigned cs_len;
    int unsigned cm_len;
    int unsigned olen;
    int unsigned nsend;
    int unsigned pick;
    int unsigned base;
    logic [15:0] otype;
    logic [15:0] rec_len;
    logic [15:0] ext_total;
    len_t        plen;
    logic [7:0]  b;
    bit          with_last;
    pkt = {};
    pkt.push_back(TLS_HANDSHAKE);
    pkt.push_back(8'h03);
    pkt.push_back(8'($urandom_range(0, 4)));
    pkt.push_back(8'h00);
    pkt.push_back(8'h00);
    pkt.push_back(HS_CLIENT_HELLO);
    // Handshake length, client version and random are not checked.
    repeat (3 + 2 + RANDOM_LEN) pkt.push_back(8'($urandom));
    spots = '{0, 1, 2, 3, 4, 5};
    sid_len = ($urandom_range(0, 9) == 0) ? 32 : $urandom_range(0, 6);
    spots.push_back(pkt.size());
    pkt.push_back(8'(sid_len));
    repeat (sid_len) pkt.push_back(8'($urandom));
    cs_len = 2 * $urandom_range(1, 3);
    spots.push_back(pkt.size());
    spots.push_back(pkt.size() + 1);
    pkt.push_back(8'h00);
    pkt.push_back(8'(cs_len));
    repeat (cs_len) pkt.push_back(8'($urandom));
    cm_len = $urandom_range(1, 2);
    spots.push_back(pkt.size());
    pkt.push_back(8'(cm_len));
    repeat (cm_len) pkt.push_back(8'($urandom));
    ext_len_at = pkt.size();
    spots.push_back(ext_len_at);
    spots.push_back(ext_len_at + 1);
    pkt.push_back(8'h00);
    pkt.push_back(8'h00);
    ext_start = pkt.size();
    n_before = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
    n_slots  = n_before + 1 + (($urandom_range(0, 3) == 0) ? 1 : 0);
    for (int unsigned e = 0; e < n_slots; e++) begin
      base = pkt.size();
      if (e == n_before && kind != PK_NO_SNI) begin
        name_len = (kind == PK_EMPTY_NAME) ? 0 : $urandom_range(1, 16);
        for (int unsigned k = 0; k < 9; k++) sni_spots.push_back(base + k);
        pkt.push_back(EXT_SERVER_NAME[15:8]);
        pkt.push_back(EXT_SERVER_NAME[7:0]);
        pkt.push_back(8'h00);
        pkt.push_back(8'(SNI_MIN_EXT + name_len));
        pkt.push_back(8'h00);
        pkt.push_back(8'(SNI_MIN_LIST + name_len));
        pkt.push_back(SNI_HOST_NAME);
        pkt.push_back(8'h00);
        pkt.push_back(8'(name_len));
        repeat (name_len) pkt.push_back(8'($urandom));
      end else begin
        otype = 16'($urandom_range(1, 16'hFFFF));
        olen  = $urandom_range(0, 6);
        for (int unsigned k = 0; k < EXT_HDR_LEN; k++) spots.push_back(base + k);
        pkt.push_back(otype[15:8]);
        pkt.push_back(otype[7:0]);
        pkt.push_back(8'h00);
        pkt.push_back(8'(olen));
        repeat (olen) pkt.push_back(8'($urandom));
      end
    end
    ext_total = 16'(pkt.size() - ext_start);
    // A list length past the packet end is clamped by the block.
    if (kind == PK_GOOD && $urandom_range(0, 3) == 0) begin
      ext_total = ext_total + 16'($urandom_range(1, 200));
    end
    pkt[ext_len_at]     = ext_total[15:8];
    pkt[ext_len_at + 1] = ext_total[7:0];
    rec_len = 16'(pkt.size() - REC_HDR_LEN);
    if ($urandom_range(0, 4) == 0) rec_len = 16'($urandom_range(0, rec_len));
    pkt[3] = rec_len[15:8];
    pkt[4] = rec_len[7:0];

    plen      = len_t'(pkt.size());
    nsend     = pkt.size();
    with_last = 1'b1;
    case (kind)
      PK_CORRUPT: begin
        pick      = spots[$urandom_range(0, spots.size() - 1)];
        pkt[pick] = pkt[pick] ^ 8'($urandom_range(1, 255));
      end
      PK_BAD_SNI: begin
        if (sni_spots.size() != 0) begin
          pick = sni_spots[$urandom_range(0, sni_spots.size() - 1)];
          case ($urandom_range(0, 2))
            0:       pkt[pick] = pkt[pick] + 8'd1;
            1:       pkt[pick] = pkt[pick] - 8'd1;
            default: pkt[pick] = pkt[pick] ^ 8'($urandom_range(1, 255));
          endcase
        end
      end
      PK_TRUNCATED:  nsend = $urandom_range(1, pkt.size() - 1);
      PK_UNFINISHED: begin
        nsend     = $urandom_range(1, pkt.size());
        with_last = 1'b0;
      end
      PK_SHORT: begin
        plen  = len_t'($urandom_range(0, MIN_PKT_LEN - 1));
        nsend = $urandom_range(1, 12);
      end
      PK_OVERRUN: begin
        if ($urandom_range(0, 1) == 1) begin
          nsend = pkt.size() + $urandom_range(1, 8);
        end else begin
          plen = len_t'($urandom_range(MIN_PKT_LEN, pkt.size() - 1));
        end
      end
      PK_LONG_LEN: plen = len_t'($urandom_range(pkt.size() + 1, 65535));
      default: ;
    endcase

    for (int unsigned i = 0; i < nsend; i++) begin
      b = (i < pkt.size()) ? pkt[i] : 8'($urandom);
      send_beat(b, i == 0, with_last && (i == nsend - 1), (i == 0) ? plen : len_t'($urandom));
      packet_beats++;
    end
    packets_sent++;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // Directed beats: stray bytes before any packet, one-byte packets, the
    // shortest accepted header, and early header rejections.
    send_beat(8'hFF, 1'b0, 1'b0, 16'hFFFF);
    send_beat(8'h00, 1'b0, 1'b1, 16'h0000);
    send_beat(8'h16, 1'b1, 1'b1, 16'hFFFF);
    send_beat(8'h00, 1'b1, 1'b1, 16'h0000);
    for (int i = 0; i < 9; i++) begin
      send_beat(MIN_HELLO[71 - 8 * i -: 8], i == 0, i == 8,
                (i == 0) ? len_t'(MIN_PKT_LEN) : len_t'($urandom));
    end
    send_beat(8'h17, 1'b1, 1'b0, len_t'(MIN_PKT_LEN));
    send_beat(8'h03, 1'b0, 1'b0, len_t'($urandom));
    send_beat(8'h03, 1'b0, 1'b1, len_t'($urandom));
    send_beat(TLS_HANDSHAKE, 1'b1, 1'b0, len_t'(MIN_PKT_LEN - 1));
    send_beat(8'h03, 1'b0, 1'b1, len_t'($urandom));
    send_beat(TLS_HANDSHAKE, 1'b1, 1'b0, 16'd20);
    send_beat(8'h03, 1'b0, 1'b0, len_t'($urandom));
    send_beat(8'h05, 1'b0, 1'b1, len_t'($urandom));
    send_beat(TLS_HANDSHAKE, 1'b1, 1'b0, 16'd20);
    send_beat(8'h02, 1'b0, 1'b0, len_t'($urandom));
    send_beat(8'hFF, 1'b0, 1'b1, len_t'($urandom));
    // Left open on purpose: the next packet restarts without a verdict.
    send_beat(TLS_HANDSHAKE, 1'b1, 1'b0, 16'd64);
    send_beat(8'h03, 1'b0, 1'b0, len_t'($urandom));

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 81;
        end
        1: begin
          send_idle_pct = 81;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      while (packet_beats < BEATS_PER_RUN * (phase + 1)) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            send_beat(8'($urandom), 1'b0, $urandom_range(0, 3) == 0, len_t'($urandom));
          end
        end
        run_packet(choose_kind(packets_sent));
      end
      // Hold the sender off until every result of this phase has come out.
      drain_results();
    end

    repeat (20) @(negedge clk_i);
    $display("Sent %0d packets in %0d beats; saw %0d hostname bytes and %0d verdicts.",
             packets_sent, packet_beats, name_beats, verdicts);
    $display("%0d verdicts reported a hostname; %0d mismatches.", found_verdicts, mismatches);
    if (mismatches == 0) begin
      $display("** tls_sni_hostname_extractor: PASSED **");
    end else begin
      $display("** tls_sni_hostname_extractor: FAILED **");
    end
    $finish;
  end

endmodule

[tls_sni_hostname_extractor.f]
+incdir+hdl
hdl/tlssni_pkg.sv
hdl/tls_sni_hostname_extractor.sv
dv/tls_sni_hostname_checker.sv
dv/tls_sni_hostname_extractor_test.sv
